>>> hdl/most_frequent_value_finder_core_assert.svh
// assertion helpers shared by the checker
`ifndef MOST_FREQUENT_VALUE_FINDER_CORE_ASSERT_SVH
`define MOST_FREQUENT_VALUE_FINDER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MFV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MFV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mfv_pkg.sv
`timescale 1ns / 1ps

package mfv_pkg;

  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam int RESULT_LIMIT = 32;
  localparam int RLIM_W       = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_PIVOT = 5'b00010,
    S_SWEEP = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

endpackage

>>> hdl/mfv_ram.sv
`timescale 1ns / 1ps

// simple dual-port ram, one write and one registered read
module mfv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/most_frequent_value_finder_core.sv
`timescale 1ns / 1ps

// Mode finder: loads a list of signed 32-bit values, one transaction per cycle, until a
// transaction with is_final set (that value belongs to the list). Up to MAX_ITEMS values
// are kept; later ones of the same list are dropped and every result of that list then
// carries dropped_items. After the final value the block stops taking input and runs one
// or two passes over the stored list through a single RAM read port: for each position i
// it counts the matches at positions i and later. The first pass finds the highest count
// and how many positions reach it; if a value repeats, the second emits each modal value
// at its first occurrence, in list order, with the count (saturated at 127), at most 32
// results, the last one flagged by final_result. If no value repeats, one result with
// all_unique set, mode_value zero and occurrence_count one is given. Each position takes a
// pivot read, a forward sweep through the read port and one check. The store needs no
// clearing after reset. The output register lets the next list start loading while the
// last result still waits to be taken.
module most_frequent_value_finder_core import mfv_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic                      is_final,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] mode_value,
  output logic        [COUNT_W-1:0] occurrence_count,
  output logic                      all_unique,
  output logic                      dropped_items,
  output logic                      final_result
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  state_t state;

  // list bookkeeping
  logic [CW-1:0]      stored;
  logic               overflow;

  // sweep sequencer
  logic [CW-1:0]      idx;        // pivot position
  logic [CW-1:0]      k;          // next address to read in the sweep
  logic               first;      // first sweep cycle, pivot data on the read port
  logic               pend;       // read data of a compare position is on the port
  logic [VALUE_W-1:0] pivot;
  logic [CW-1:0]      cnt;        // forward match count of the pivot
  logic [CW-1:0]      best;
  logic [RLIM_W-1:0]  total;      // positions reaching best, capped at the result limit
  logic [RLIM_W-1:0]  emitted;
  logic               tally_pass; // 0: find best, 1: emit modes

  // ram ports
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               in_xact;
  logic               out_free;
  logic               sweep_issue;
  logic               sweep_done;
  logic               last_pos;
  logic [CW-1:0]      best_next;
  logic               emit_go;
  logic               emit_last;
  logic [XW-1:0]      best_x;
  logic [COUNT_W-1:0] best_sat;

  assign in_ready = (state == S_LOAD);
  assign in_xact  = in_valid && in_ready;

  // values past capacity are not written
  assign ram_we    = in_xact && (stored < CW'(MAX_ITEMS));
  assign ram_raddr = (state == S_PIVOT) ? idx[AW-1:0] : k[AW-1:0];

  mfv_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored[AW-1:0]),
    .wdata (item_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free    = !out_valid || out_ready;
  assign sweep_issue = (k < stored);
  assign sweep_done  = (state == S_SWEEP) && !first && !pend && !sweep_issue;
  assign last_pos    = ((idx + CW'(1)) == stored);
  assign best_next   = (cnt > best) ? cnt : best;

  // a unique-list result is always the only one; modes end at the capped total
  assign emit_go   = (state == S_EMIT) && out_free;
  assign emit_last = !tally_pass || ((emitted + RLIM_W'(1)) == total);

  // count saturates at the field ceiling
  assign best_x   = XW'(best);
  assign best_sat = (best_x > XW'(COUNT_MAX)) ? COUNT_MAX : best_x[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      stored     <= '0;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      k          <= '0;
      first      <= 1'b0;
      pend       <= 1'b0;
      cnt        <= '0;
      best       <= '0;
      total      <= '0;
      emitted    <= '0;
      tally_pass <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_xact) begin
            if (stored < CW'(MAX_ITEMS)) begin
              stored <= stored + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (is_final) begin
              idx        <= '0;
              tally_pass <= 1'b0;
              best       <= CW'(1);
              total      <= '0;
              state      <= S_PIVOT;
            end
          end
        end
        S_PIVOT: begin
          // pivot read goes out now, compares start one past it
          k     <= idx + CW'(1);
          first <= 1'b1;
          pend  <= 1'b0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          first <= 1'b0;
          pend  <= sweep_issue;
          if (sweep_issue) begin
            k <= k + CW'(1);
          end
          if (first) begin
            cnt <= CW'(1);
          end else if (pend && (ram_rdata == pivot)) begin
            cnt <= cnt + CW'(1);
          end
          if (sweep_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!tally_pass) begin
            best <= best_next;
            if (cnt > best) begin
              total <= RLIM_W'(1);
            end else if ((cnt == best) && (total != RLIM_W'(RESULT_LIMIT))) begin
              total <= total + RLIM_W'(1);
            end
            if (last_pos) begin
              if (best_next > CW'(1)) begin
                tally_pass <= 1'b1;
                idx        <= '0;
                emitted    <= '0;
                state      <= S_PIVOT;
              end else begin
                state <= S_EMIT;
              end
            end else begin
              idx   <= idx + CW'(1);
              state <= S_PIVOT;
            end
          end else begin
            if (cnt == best) begin
              state <= S_EMIT;
            end else if (last_pos) begin
              // cannot happen once a mode is known, close the list anyway
              stored   <= '0;
              overflow <= 1'b0;
              state    <= S_LOAD;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_PIVOT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (emit_last) begin
              stored   <= '0;
              overflow <= 1'b0;
              state    <= S_LOAD;
            end else begin
              emitted <= emitted + RLIM_W'(1);
              idx     <= idx + CW'(1);
              state   <= S_PIVOT;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state == S_SWEEP) && first) begin
      pivot <= ram_rdata;
    end
    if (emit_go) begin
      mode_value       <= tally_pass ? pivot : '0;
      occurrence_count <= tally_pass ? best_sat : COUNT_W'(1);
      all_unique       <= !tally_pass;
      dropped_items    <= overflow;
      final_result     <= emit_last;
    end
  end

endmodule

>>> hdl/mfv_checker.sv
`timescale 1ns / 1ps

`include "most_frequent_value_finder_core_assert.svh"

module mfv_checker import mfv_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic signed [VALUE_W-1:0] item_value,
  input logic                      is_final,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] mode_value,
  input logic        [COUNT_W-1:0] occurrence_count,
  input logic                      all_unique,
  input logic                      dropped_items,
  input logic                      final_result
);

  // stalled result holds
  `MFV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode_value) && $stable(final_result), "result changed while stalled")

  // the all-unique result stands alone with fixed fields
  `MFV_ASSERT_NOW(a_unique_fields, out_valid && all_unique, final_result && (mode_value == '0) && (occurrence_count == COUNT_W'(1)), "bad all-unique result")

  // a mode repeats at least twice
  `MFV_ASSERT_NOW(a_mode_count, out_valid && !all_unique, occurrence_count > COUNT_W'(1), "mode with count below two")

  // a non-final value never produces a result
  `MFV_ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !is_final && !out_valid, !out_valid, "result before final value")

endmodule

bind most_frequent_value_finder_core mfv_checker u_mfv_checker (.*);
